// ----- sv/stereo_echo_delay_line_unit_defines.svh -----
// assertion macros for the stereo echo delay line
// used by the top level only, expects clk and rst_n in scope
`ifndef STEREO_ECHO_DELAY_LINE_UNIT_DEFINES_SVH
`define STEREO_ECHO_DELAY_LINE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SEDL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SEDL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sedl_pkg.sv -----
// types and constants for the stereo echo delay line
// no dependencies
`default_nettype none

package sedl_pkg;

    // sample and register widths
    localparam int SAMPLE_W   = 16;
    localparam int PAIR_W     = 2 * SAMPLE_W;
    localparam int LEN_W      = 17;
    localparam int GAIN_W     = 15;
    localparam int CFG_DATA_W = LEN_W;
    localparam int CFG_IDX_W  = 1;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int FRAC_W     = 15;

    // register reset values
    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(16384);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(13107);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN    = CFG_IDX_W'(1);

    // saturation limits
    localparam logic signed [SAMPLE_W+1:0] SAT_MAX = (SAMPLE_W+2)'(32767);
    localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -(SAMPLE_W+2)'(32768);

    // rounding offset for truncation toward zero
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_W) - 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

// ----- sv/stereo_echo_delay_line_unit.sv -----
// stereo echo delay line: ring memory read-modify-write and echo mix
// depends on sedl_pkg and stereo_echo_delay_line_unit_defines.svh
//
// channel   dir  signals                         content
// s_*       in   s_tvalid s_tready s_tdata       left_in, right_in
// m_*       out  m_tvalid m_tready m_tdata       left_out, right_out
// cfg_*     in   cfg_we cfg_index cfg_data       delay_length, echo_gain
//
// one item per cycle sustained while m_tready holds high; m_tvalid follows the accepting
// edge through the ring read register, multiply register and mix/saturate output register
// each item reads and writes one ring entry at its accepting edge, read-first
// no clearing pass after reset: a fill count marks the written prefix of the
// ring and entries beyond it read as zero
// m_tready stalls back up the stages; s_tready drops only when all three are full
`default_nettype none
`include "stereo_echo_delay_line_unit_defines.svh"

module stereo_echo_delay_line_unit
    import sedl_pkg::*;
#(
    parameter int MAX_DELAY = 65536
) (
    input  wire                    clk,
    input  wire                    rst_n,
    // stream input
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [PAIR_W-1:0]      s_tdata,   // [15:0] left_in, [31:16] right_in
    // stream output
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [PAIR_W-1:0]      m_tdata,   // [15:0] left_out, [31:16] right_out
    // configuration
    input  wire                    cfg_we,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam logic [LW-1:0] MAX_L = LW'(MAX_DELAY);
    localparam logic [31:0]   MAX_W = 32'(MAX_DELAY);

    // configuration registers
    logic [LEN_W-1:0]  len_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELAY_LENGTH: len_reg  <= cfg_data;
                REG_ECHO_GAIN:    gain_reg <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective ring length, clamped to one..MAX_DELAY
    logic [LW-1:0] eff_len;

    always_comb
    begin
        if (len_reg == '0)
            eff_len = LW'(1);
        else if (32'(len_reg) > MAX_W)
            eff_len = MAX_L;
        else
            eff_len = LW'(len_reg);
    end

    // pipeline handshake
    logic s1_vld_reg, s2_vld_reg, m_vld_reg;
    logic out_ready, s2_ready, accept;

    assign out_ready = !m_vld_reg || m_tready;
    assign s2_ready  = !s2_vld_reg || out_ready;
    assign s_tready  = !s1_vld_reg || s2_ready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_vld_reg;

    // ring position and fill count
    logic [AW-1:0] pos_reg, pos_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] pos_ext, pos_inc;
    logic          hit;

    assign pos_ext = LW'(pos_reg);
    assign pos_inc = pos_ext + LW'(1);
    assign hit     = pos_ext < fill_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (cfg_we && cfg_index == REG_DELAY_LENGTH)
            pos_next = '0;
        else if (accept)
        begin
            pos_next = (pos_inc >= eff_len) ? '0 : AW'(pos_inc);
            if (!hit)
                fill_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    // ring memory, read-first on the shared address
    logic [PAIR_W-1:0] ring_mem [MAX_DELAY];
    logic [PAIR_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg            <= ring_mem[pos_reg];
            ring_mem[pos_reg] <= s_tdata;
        end
    end

    // stage 1 payload: input pair and written-prefix flag
    logic [PAIR_W-1:0] s1_in_reg;
    logic              s1_hit_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_reg  <= s_tdata;
            s1_hit_reg <= hit;
        end
    end

    // stage 1: scale the delayed pair by the gain
    sample_t d_l, d_r;
    logic signed [GAIN_W:0] gain_s;

    assign d_l    = s1_hit_reg ? sample_t'(rd_reg[SAMPLE_W-1:0])      : '0;
    assign d_r    = s1_hit_reg ? sample_t'(rd_reg[PAIR_W-1:SAMPLE_W]) : '0;
    assign gain_s = $signed({1'b0, gain_reg});

    logic signed [PROD_W-1:0] prod_l_reg, prod_r_reg;
    logic [PAIR_W-1:0]        s2_in_reg;
    logic                     s1_move;

    assign s1_move = s1_vld_reg && s2_ready;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            prod_l_reg <= PROD_W'(gain_s) * PROD_W'(d_l);
            prod_r_reg <= PROD_W'(gain_s) * PROD_W'(d_r);
            s2_in_reg  <= s1_in_reg;
        end
    end

    // stage 2: truncate toward zero, add, saturate
    function automatic sample_t mix(input sample_t x, input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]   biased;
        logic signed [SAMPLE_W:0]   echo;
        logic signed [SAMPLE_W+1:0] sum;
        biased = p + (p[PROD_W-1] ? TRUNC_BIAS : '0);
        echo   = $signed(biased[FRAC_W+SAMPLE_W:FRAC_W]);
        sum    = (SAMPLE_W+2)'(x) + (SAMPLE_W+2)'(echo);
        if (sum > SAT_MAX)
            mix = sample_t'(SAT_MAX);
        else if (sum < SAT_MIN)
            mix = sample_t'(SAT_MIN);
        else
            mix = sample_t'(sum);
    endfunction

    logic s2_move;
    assign s2_move = s2_vld_reg && out_ready;

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            m_tdata[SAMPLE_W-1:0]      <= mix(sample_t'(s2_in_reg[SAMPLE_W-1:0]), prod_l_reg);
            m_tdata[PAIR_W-1:SAMPLE_W] <= mix(sample_t'(s2_in_reg[PAIR_W-1:SAMPLE_W]),
                                              prod_r_reg);
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_vld_reg <= s_tvalid;
            if (s2_ready)
                s2_vld_reg <= s1_vld_reg;
            if (out_ready)
                m_vld_reg <= s2_vld_reg;
        end
    end

    // checks
    `SEDL_ASSERT_IMP(a_pos_in_ring, 1'b1, pos_ext < eff_len, "ring position beyond length")
    `SEDL_ASSERT_IMP(a_fill_covers_pos, 1'b1, pos_ext <= fill_reg, "gap in written prefix")
    `SEDL_ASSERT_NXT(a_accept_loads, accept, s1_vld_reg, "accepted item lost in stage 1")
    `SEDL_ASSERT_IMP(a_full_holds, s1_vld_reg && s2_vld_reg && m_vld_reg && !m_tready,
                     !s_tready, "item overwritten while stalled")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for stereo_echo_delay_line_unit: directed table, then random phases
// depends on sedl_pkg and the unit's rtl; a built-in ring model predicts each output pair unless the row types one
`timescale 1ns / 1ps

module tb_top
    import sedl_pkg::*;
();

    localparam int RING_DEPTH   = 65536;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SEGMENTS     = 12;
    localparam int SEG_ITEMS    = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_DIRECTED   = 23;

    // one stereo pair, laid out as on tdata
    typedef struct packed {
        sample_t right;
        sample_t left;
    } stereo_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        sample_t                left;
        sample_t                right;
        logic                   typed;
        sample_t                exp_left;
        sample_t                exp_right;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PAIR_W-1:0]      s_tdata = '0;   // [15:0] left_in, [31:16] right_in
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [PAIR_W-1:0]      m_tdata;        // [15:0] left_out, [31:16] right_out
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // hand-typed expectation riding along with the item on the bus
    logic                   typed_valid = 1'b0;
    stereo_t                typed_pair = '0;

    // ring model state
    stereo_t                pair_ring [RING_DEPTH];
    int                     ring_pos = 0;
    logic [LEN_W-1:0]       ring_len_reg = LEN_RESET;
    logic [GAIN_W-1:0]      gain_reg = GAIN_RESET;
    stereo_t                pending_pairs [$];

    int                     fail_count = 0;
    int                     cycle_count = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_left = 0;

    stim_row_t directed [N_DIRECTED] = '{
        // after reset the ring is empty, so the input passes through
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
        '{ROW_ITEM, '0, '0, 16'hFFFF, 16'h0001, 1'b1, 16'hFFFF, 16'h0001},
        '{ROW_REG, REG_DELAY_LENGTH, 17'd1, '0, '0, 1'b0, '0, '0},
        '{ROW_REG, REG_ECHO_GAIN, 17'd32767, '0, '0, 1'b0, '0, '0},
        // full gain on full-scale echo, both rails saturate
        '{ROW_ITEM, '0, '0, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
        '{ROW_ITEM, '0, '0, 16'h0000, 16'h0000, 1'b1, 16'sd32766, 16'h8001},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
        '{ROW_REG, REG_ECHO_GAIN, 17'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'sd100, -16'sd100, 1'b1, 16'sd100, -16'sd100},
        // zero length behaves as one
        '{ROW_REG, REG_DELAY_LENGTH, 17'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_REG, REG_ECHO_GAIN, 17'(GAIN_RESET), '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'sd1234, -16'sd4321, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, -16'sd7, 16'sd7, 1'b0, '0, '0},
        // length beyond the ring clamps to the ring size
        '{ROW_REG, REG_DELAY_LENGTH, 17'd131071, '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'sd5, -16'sd5, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'sd16, 16'sd17, 1'b1, 16'sd16, 16'sd17},
        '{ROW_REG, REG_DELAY_LENGTH, 17'd65536, '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h5555, 16'hAAAA, 1'b0, '0, '0},
        '{ROW_REG, REG_DELAY_LENGTH, 17'd3, '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'sd1000, -16'sd1000, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'sd2000, -16'sd2000, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'sd3000, -16'sd3000, 1'b1, 16'sd3000, -16'sd3000},
        // echo of 1000 at about 0.4 truncates toward zero on both signs
        '{ROW_ITEM, '0, '0, 16'sd4000, -16'sd4000, 1'b1, 16'sd4399, -16'sd4399}
    };

    stereo_echo_delay_line_unit #(
        .MAX_DELAY(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // input plus gain times delayed sample, product truncated toward zero, sum clamped
    function automatic sample_t echo_mix(input sample_t x, input sample_t d, input int gain);
        int prod;
        int mag;
        int echo;
        int sum;
        prod = gain * int'(d);
        mag = (prod < 0) ? -prod : prod;
        echo = mag >> 15;
        if (prod < 0)
            echo = -echo;
        sum = int'(x) + echo;
        if (sum > 32767)
            sum = 32767;
        if (sum < -32768)
            sum = -32768;
        return sample_t'(sum);
    endfunction

    // read-then-write one ring entry and advance the position
    function automatic stereo_t step_ring(input stereo_t x);
        int len;
        int pos;
        stereo_t held;
        stereo_t y;
        len = int'(ring_len_reg);
        if (len == 0)
            len = 1;
        if (len > RING_DEPTH)
            len = RING_DEPTH;
        pos = ring_pos;
        if (pos >= len)
            pos = 0;
        held = pair_ring[pos];
        y.left = echo_mix(x.left, held.left, int'(gain_reg));
        y.right = echo_mix(x.right, held.right, int'(gain_reg));
        pair_ring[pos] = x;
        pos++;
        if (pos >= len)
            pos = 0;
        ring_pos = pos;
        return y;
    endfunction

    task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
        $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // output check, then model update for an accepted item or a register write
    always @(posedge clk)
    begin : watch
        stereo_t got;
        stereo_t want;
        stereo_t fresh;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_pairs.size() == 0)
                    report_mismatch("output item with none pending, left", got.left, '0);
                else
                begin
                    want = pending_pairs.pop_front();
                    if (got.left !== want.left)
                        report_mismatch("left_out", got.left, want.left);
                    if (got.right !== want.right)
                        report_mismatch("right_out", got.right, want.right);
                end
            end
            if (s_tvalid && s_tready)
            begin
                fresh = step_ring(stereo_t'(s_tdata));
                if (typed_valid)
                    fresh = typed_pair;
                pending_pairs.push_back(fresh);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_DELAY_LENGTH)
                begin
                    ring_len_reg = cfg_data;
                    ring_pos = 0;
                end
                else if (cfg_index == REG_ECHO_GAIN)
                    gain_reg = cfg_data[GAIN_W-1:0];
            end
        end
    end

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("stereo_echo_delay_line_unit: mismatch");
            $finish;
        end
    end

    // offer one item after a random idle gap, return at the accepting edge
    task automatic send_pair(input sample_t l, input sample_t r, input logic typed,
                             input sample_t el, input sample_t er);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        typed_valid <= typed;
        typed_pair <= {er, el};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and wait until every pending pair has come out
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        typed_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // extremes, tiny values and full-range noise
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return sample_t'(int'($urandom_range(16)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // main sequence
    initial
    begin
        int seg;
        int n;
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] gain;
        foreach (pair_ring[i])
            pair_ring[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (n = 0; n < N_DIRECTED; n++)
        begin
            if (directed[n].kind == ROW_REG)
                write_reg(directed[n].idx, directed[n].val);
            else
                send_pair(directed[n].left, directed[n].right, directed[n].typed,
                          directed[n].exp_left, directed[n].exp_right);
        end

        // random segments, each with its own setting and idle pattern
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case ($urandom_range(9))
                0: len = '0;
                1: len = 17'd1;
                2: len = 17'd65536;
                3: len = 17'($urandom_range(131071, 65537));
                default: len = 17'($urandom_range(40, 2));
            endcase
            case ($urandom_range(5))
                0: gain = '0;
                1: gain = 17'd32767;
                default: gain = 17'($urandom_range(32767));
            endcase
            write_reg(REG_DELAY_LENGTH, len);
            write_reg(REG_ECHO_GAIN, gain);
            settle();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            // back up the pipeline once while items keep coming
            if (seg == 4)
                hold_left = HOLD_CYCLES;
            for (n = 0; n < SEG_ITEMS; n++)
                send_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
        end

        settle();
        if (fail_count == 0)
            $display("stereo_echo_delay_line_unit: match");
        else
            $display("stereo_echo_delay_line_unit: mismatch");
        $finish;
    end

endmodule

// ----- stereo_echo_delay_line_unit.f -----
+incdir+sv
sv/sedl_pkg.sv
sv/stereo_echo_delay_line_unit.sv
bench/tb_top.sv
